FILE: rtl/core/scca_pkg.sv
// Shared types and constants for the size-class chunk allocator.
package scca_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_FOREIGN  = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int unsigned SizeW  = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned NumRegClasses = 4;
  localparam int unsigned CfgIdxW = 3;

  typedef struct packed {
    logic        op;
    logic [23:0] req_size;
    logic [23:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] chunk_addr;
    logic [1:0]  class_index;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [SizeW-1:0]   data;
  } cfg_t;

endpackage

FILE: rtl/core/scca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module scca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/size_class_chunk_allocator.sv
// Top level of the size-class chunk allocator.
// Size-class chunk allocator.
// Input channel (req_valid_i/req_ready_o, req_i): one transaction is either an
// allocate (op 0, req_size) or a free (op 1, free_addr). Every transaction
// gives exactly one response on rsp_valid_o/rsp_ready_i, rsp_o: status, chunk
// offset and class index.
// Configuration channel (cfg_valid_i/cfg_ready_o, cfg_i): indexes 0..3 set the
// class sizes, 4..7 the chunk counts. Any write returns every class to all
// chunks free. Write only while idle; a pending write holds off the input.
// The chunk order table lives in one RAM (NUM_CLASSES*MAX_CHUNKS entries,
// one read and one write a cycle, read registered); entry j of a class whose
// position is at or beyond the fill mark (one past the highest position written
// since the last clear) reads as j, so no clearing pass is needed. A free writes
// back every entry it searches, so written positions always start at 0.
// Allocate: class bases, class pick, one RAM read, then a multiply and an add.
// Free: class bases, address classification, then a search over the used
// entries (read, then compare and write back), then a shift down of the later
// entries (read, then write), then the freed index is written at the new end.
// One transaction is in flight at a time, set by the single RAM port pair.
// Reset clears sizes, chunk counts, used counts, fill marks and control state;
// the block is ready at once. A stalled receiver holds the response in the
// output register; the input is not taken until it has been delivered.
module size_class_chunk_allocator
  import scca_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = 4,
  parameter int unsigned MAX_CHUNKS  = 64,
  parameter int unsigned ADDR_BITS   = 24,
  parameter int unsigned ALIGN_BYTES = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  cfg_t cfg_i
);

  localparam int unsigned ClsW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SlotW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned Depth = NUM_CLASSES * MAX_CHUNKS;
  localparam int unsigned RamAW = (Depth > 1) ? $clog2(Depth) : 1;
  // wide enough for total pool bytes: 17-bit size times count, summed
  localparam int unsigned BW    = SizeW + 1 + CntW + ClsW + 1;
  localparam int unsigned AlW   = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_BASE, S_CLASS, S_ARD, S_AWAIT, S_AMUL, S_SRD, S_SCHK,
    S_SHRD, S_SHWR, S_FIN, S_RSP
  } state_e;

  // configuration and per-class use
  logic [SizeW-1:0]  size_q [NUM_CLASSES];
  logic [CntW-1:0]   total_q [NUM_CLASSES];
  logic [CntW-1:0]   used_q [NUM_CLASSES];
  logic [CntW-1:0]   fill_q [NUM_CLASSES];

  // rounded chunk sizes (a multiple of ALIGN_BYTES, up to 17 bits)
  logic [SizeW:0] csz [NUM_CLASSES];
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      logic [SizeW+AlW:0] t;
      t = {{AlW{1'b0}}, 1'b0, size_q[c]} + (SizeW+AlW+1)'(ALIGN_BYTES - 1);
      csz[c] = (SizeW+1)'((t / ALIGN_BYTES) * ALIGN_BYTES);
    end
  end

  state_e state_q;
  req_t   req_q;
  rsp_t   rsp_q;
  logic   rsp_v_q;
  logic [ClsW-1:0]  cnt_q;    // class walk index
  logic [BW-1:0]    acc_q;    // running base
  logic [BW-1:0]    base_q [NUM_CLASSES];
  logic [ClsW-1:0]  cls_q;
  logic [CntW-1:0]  j_q;
  logic [SlotW-1:0] hold_q;   // freed chunk index
  logic [BW-1:0]    prod_q;

  // RAM
  logic             we;
  logic [RamAW-1:0] waddr, raddr;
  logic [SlotW-1:0] wdata, rdata;
  logic [CntW-1:0]  rd_pos_q;
  logic             rd_fill_q;

  scca_ram #(.Width(SlotW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [RamAW-1:0] ent(logic [ClsW-1:0] c, logic [CntW-1:0] p);
    logic [RamAW+CntW:0] a;
    a = (RamAW+CntW+1)'(c) * (RamAW+CntW+1)'(MAX_CHUNKS) + (RamAW+CntW+1)'(p);
    return a[RamAW-1:0];
  endfunction

  // entries never written since the last clear read as their own position
  logic [SlotW-1:0] rd_val;
  assign rd_val = rd_fill_q ? rdata : rd_pos_q[SlotW-1:0];

  logic [CntW-1:0] rd_pos;
  logic            rd_en;
  always_comb begin
    rd_pos = j_q;
    case (state_q)
      S_ARD:  rd_pos = used_q[cls_q];
      S_SHRD: rd_pos = j_q + CntW'(1);
      default: rd_pos = j_q;
    endcase
    raddr = ent(cls_q, rd_pos);
    rd_en = (state_q == S_ARD) || (state_q == S_SRD) || (state_q == S_SHRD);
  end

  logic [CntW-1:0] wpos;
  always_comb begin
    we = 1'b0;
    wpos = j_q;
    wdata = rd_val;
    case (state_q)
      // searched entry written back, keeps the written positions contiguous
      S_SCHK: begin
        we = 1'b1;
        wpos = j_q;
        wdata = rd_val;
      end
      S_SHWR: begin
        we = 1'b1;
        wpos = j_q;
        wdata = rd_val;
      end
      S_FIN: begin
        we = 1'b1;
        wpos = used_q[cls_q] - CntW'(1);
        wdata = hold_q;
      end
      default: ;
    endcase
    waddr = ent(cls_q, wpos);
  end

  logic cfg_fire, req_fire;
  assign req_ready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign req_fire    = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  logic [BW-1:0] faddr;
  assign faddr = BW'(req_q.free_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rsp_v_q <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        size_q[c]  <= '0;
        total_q[c] <= '0;
        used_q[c]  <= '0;
        fill_q[c]  <= '0;
      end
      cnt_q <= '0;
      acc_q <= '0;
      cls_q <= '0;
      j_q   <= '0;
      rd_pos_q  <= '0;
      rd_fill_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_pos_q  <= rd_pos;
        rd_fill_q <= rd_pos < fill_q[cls_q];
      end
      if (we && (wpos >= fill_q[cls_q])) begin
        fill_q[cls_q] <= wpos + CntW'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (cfg_fire) begin
            if (cfg_i.index < CfgIdxW'(NumRegClasses)) begin
              if (32'(cfg_i.index) < NUM_CLASSES) size_q[ClsW'(cfg_i.index)] <= cfg_i.data;
            end else begin
              if (32'(cfg_i.index) - NumRegClasses < NUM_CLASSES) begin
                total_q[ClsW'(cfg_i.index - CfgIdxW'(NumRegClasses))] <=
                  (cfg_i.data[CountW-1:0] > CountW'(MAX_CHUNKS)) ?
                  CntW'(MAX_CHUNKS) : CntW'(cfg_i.data[CountW-1:0]);
              end
            end
            for (int c = 0; c < NUM_CLASSES; c++) begin
              used_q[c] <= '0;
              fill_q[c] <= '0;
            end
          end else if (req_fire) begin
            req_q <= req_i;
            cnt_q <= '0;
            acc_q <= '0;
            state_q <= S_BASE;
          end
        end
        // class bases, one multiply a cycle
        S_BASE: begin
          base_q[cnt_q] <= acc_q;
          acc_q <= acc_q + BW'(csz[cnt_q]) * BW'(total_q[cnt_q]);
          if (32'(cnt_q) == NUM_CLASSES - 1) begin
            state_q <= S_CLASS;
          end else begin
            cnt_q <= cnt_q + ClsW'(1);
          end
        end
        S_CLASS: begin
          if (req_q.op == OP_ALLOC) begin
            logic hit;
            logic [ClsW-1:0] sel;
            hit = 1'b0;
            sel = '0;
            for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
              if ((24'(csz[c]) >= req_q.req_size) && (used_q[c] < total_q[c])) begin
                hit = 1'b1;
                sel = ClsW'(c);
              end
            end
            cls_q <= sel;
            if (hit) begin
              rsp_q <= '0;
              state_q <= S_ARD;
            end else begin
              rsp_q <= '{status: ST_NO_FIT, chunk_addr: '0, class_index: '0};
              state_q <= S_RSP;
            end
          end else if (faddr >= acc_q) begin
            rsp_q <= '{status: ST_FOREIGN, chunk_addr: '0, class_index: '0};
            state_q <= S_RSP;
          end else begin
            logic hit;
            logic [ClsW-1:0] sel;
            hit = 1'b0;
            sel = '0;
            for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
              if ((faddr >= base_q[c]) &&
                  (faddr < base_q[c] + BW'(csz[c]) * BW'(total_q[c]))) begin
                hit = 1'b1;
                sel = ClsW'(c);
              end
            end
            cls_q <= sel;
            j_q <= '0;
            if (hit) begin
              rsp_q <= '0;
              state_q <= S_SRD;
            end else begin
              rsp_q <= '{status: ST_NOT_USED, chunk_addr: '0, class_index: '0};
              state_q <= S_RSP;
            end
          end
        end
        S_ARD: state_q <= S_AWAIT;
        S_AWAIT: begin
          prod_q <= BW'(rd_val) * BW'(csz[cls_q]);
          state_q <= S_AMUL;
        end
        S_AMUL: begin
          logic [BW-1:0] a;
          a = base_q[cls_q] + prod_q;
          rsp_q.chunk_addr  <= 24'(a & BW'((64'd1 << ADDR_BITS) - 64'd1));
          rsp_q.class_index <= 2'(cls_q);
          used_q[cls_q] <= used_q[cls_q] + CntW'(1);
          state_q <= S_RSP;
        end
        // search: read entry j, compare next cycle
        S_SRD: begin
          if (j_q >= used_q[cls_q]) begin
            rsp_q.status <= ST_NOT_USED;
            state_q <= S_RSP;
          end else begin
            state_q <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (base_q[cls_q] + BW'(rd_val) * BW'(csz[cls_q]) == faddr) begin
            hold_q <= rd_val;
            state_q <= (j_q + CntW'(1) < used_q[cls_q]) ? S_SHRD : S_FIN;
          end else begin
            j_q <= j_q + CntW'(1);
            state_q <= S_SRD;
          end
        end
        // shift: read k+1, write it to k
        S_SHRD: state_q <= S_SHWR;
        S_SHWR: begin
          j_q <= j_q + CntW'(1);
          state_q <= (j_q + CntW'(2) < used_q[cls_q]) ? S_SHRD : S_FIN;
        end
        S_FIN: begin
          used_q[cls_q] <= used_q[cls_q] - CntW'(1);
          rsp_q.class_index <= 2'(cls_q);
          state_q <= S_RSP;
        end
        S_RSP: begin
          if (!rsp_v_q) rsp_v_q <= 1'b1;
          else if (rsp_ready_i) begin
            rsp_v_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a response is only offered while finishing a transaction
  a_rsp_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q |-> state_q == S_RSP) else $error("response outside RSP");
  // the selected class's used count never exceeds its chunk count
  a_used_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q[cls_q] <= total_q[cls_q]) else $error("used count overflow");
  // a taken response returns to idle
  a_rsp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q && rsp_ready_i |=> state_q == S_IDLE) else $error("no return to idle");

endmodule
